[src/tpgd_pkg.sv]
// shared types and constants for the touch peak gesture dispatcher
// no dependencies
package tpgd_pkg;

   localparam int TIME_BITS_DEF = 48;
   localparam logic [31:0] LOCKOUT_RESET = 32'(1500 * 1000);

   localparam int ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_ACT_THREE = 2'd0,
      REG_ACT_FOUR  = 2'd1,
      REG_ACT_FIVE  = 2'd2,
      REG_LOCKOUT   = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_GLOVEBOX = 3'd1,
      ACT_PREHEAT  = 3'd2,
      ACT_MIRRORS  = 3'd3,
      ACT_FRUNK    = 3'd4,
      ACT_TRUNK    = 3'd5,
      ACT_PORT     = 3'd6
   } action_type;

   localparam logic [2:0] CMD_GLOVEBOX   = 3'd0;
   localparam logic [2:0] CMD_PREHEAT    = 3'd1;
   localparam logic [2:0] CMD_MIRRORS    = 3'd2;
   localparam logic [2:0] CMD_CLOSURE    = 3'd3;
   localparam logic [2:0] CMD_PORT_OPEN  = 3'd4;
   localparam logic [2:0] CMD_PORT_CLOSE = 3'd5;

   localparam logic [1:0] VAL_ONE = 2'd1;
   localparam logic [1:0] VAL_TWO = 2'd2;

   typedef struct packed {
      logic       fire;
      logic       emit;
      logic [2:0] command;
      logic [1:0] command_value;
      logic       mirrors_next;
      logic       port_next;
      logic [3:0] peak_next;
   } resolve_type;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] command_value;
   } beat_type;

endpackage

[src/tpgd_resolve.sv]
// peak tracking, lockout test and action to command mapping for one sample
// depends on tpgd_pkg
module tpgd_resolve #(
   parameter int TIME_BITS = tpgd_pkg::TIME_BITS_DEF
) (
   input  logic [3:0]             touch_points,
   input  logic [TIME_BITS-1:0]   time_us,
   input  logic                   preheat_on,
   input  logic [3:0]             peak,
   input  logic [TIME_BITS-1:0]   last_fire,
   input  tpgd_pkg::action_type   act_three,
   input  tpgd_pkg::action_type   act_four,
   input  tpgd_pkg::action_type   act_five,
   input  logic [31:0]            lockout_us,
   input  logic                   mirrors_folded,
   input  logic                   port_open,
   output tpgd_pkg::resolve_type  res
);

   tpgd_pkg::action_type act;
   logic                 peak_hit;
   logic [TIME_BITS-1:0] elapsed;
   logic                 locked;

   assign elapsed = time_us - last_fire;
   assign locked  = elapsed < TIME_BITS'(lockout_us);

   always_comb begin
      act      = tpgd_pkg::ACT_NONE;
      peak_hit = 1'b1;
      unique case (peak)
         4'd3: act = act_three;
         4'd4: act = act_four;
         4'd5: act = act_five;
         default: peak_hit = 1'b0;
      endcase

      res               = '0;
      res.mirrors_next  = mirrors_folded;
      res.port_next     = port_open;
      if (touch_points != 4'd0) begin
         res.peak_next = (touch_points > peak) ? touch_points : peak;
      end else begin
         res.peak_next = 4'd0;
         res.fire      = peak_hit && (act != tpgd_pkg::ACT_NONE) && !locked;
      end

      res.emit = res.fire;
      unique case (act)
         tpgd_pkg::ACT_GLOVEBOX: begin
            res.command       = tpgd_pkg::CMD_GLOVEBOX;
            res.command_value = tpgd_pkg::VAL_ONE;
         end
         tpgd_pkg::ACT_PREHEAT: begin
            res.command       = tpgd_pkg::CMD_PREHEAT;
            res.command_value = {1'b0, ~preheat_on};
         end
         tpgd_pkg::ACT_MIRRORS: begin
            res.command       = tpgd_pkg::CMD_MIRRORS;
            res.command_value = mirrors_folded ? tpgd_pkg::VAL_TWO : tpgd_pkg::VAL_ONE;
            if (res.fire) begin
               res.mirrors_next = !mirrors_folded;
            end
         end
         tpgd_pkg::ACT_FRUNK: begin
            res.command       = tpgd_pkg::CMD_CLOSURE;
            res.command_value = tpgd_pkg::VAL_TWO;
         end
         tpgd_pkg::ACT_TRUNK: begin
            res.command       = tpgd_pkg::CMD_CLOSURE;
            res.command_value = tpgd_pkg::VAL_ONE;
         end
         tpgd_pkg::ACT_PORT: begin
            res.command       = port_open ? tpgd_pkg::CMD_PORT_CLOSE
                                          : tpgd_pkg::CMD_PORT_OPEN;
            res.command_value = tpgd_pkg::VAL_ONE;
            if (res.fire) begin
               res.port_next = !port_open;
            end
         end
         default: begin
            res.emit = 1'b0;
         end
      endcase
   end

endmodule

[src/touch_peak_gesture_dispatch_top.sv]
// top level: csr block, gesture state registers and two-entry result queue
// depends on tpgd_pkg and tpgd_resolve
// a beat's command is registered into the result queue when it is accepted and is offered on rsp from the queue head
// throughput: one req beat per cycle; req_stall rises only when both queue
// entries hold results that the rsp side has not taken
// reset (synchronous, active high): actions none, lockout 1500000 us, peak,
// last firing time and both toggles zero, queue empty
module touch_peak_gesture_dispatch_top #(
   parameter int TIME_BITS = tpgd_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [3:0]                    req_touch_points,
   input  logic [TIME_BITS-1:0]          req_time_us,
   input  logic                          req_preheat_on,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_command,
   output logic [1:0]                    rsp_command_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tpgd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   tpgd_pkg::action_type  act_three_ff, act_four_ff, act_five_ff;
   logic [31:0]           lockout_ff;
   logic [3:0]            peak_ff;
   logic [TIME_BITS-1:0]  last_fire_ff;
   logic                  mirrors_ff;
   logic                  port_ff;
   tpgd_pkg::beat_type    q0_ff, q1_ff;
   logic [1:0]            count_ff, count_in;
   tpgd_pkg::resolve_type res;
   tpgd_pkg::reg_index_type reg_idx;
   tpgd_pkg::beat_type    beat_new;
   logic                  csr_write;
   logic                  accept;
   logic                  push;
   logic                  pop;

   assign pready    = 1'b1;
   assign reg_idx   = tpgd_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (reg_idx)
         tpgd_pkg::REG_ACT_THREE: prdata = {29'd0, act_three_ff};
         tpgd_pkg::REG_ACT_FOUR:  prdata = {29'd0, act_four_ff};
         tpgd_pkg::REG_ACT_FIVE:  prdata = {29'd0, act_five_ff};
         tpgd_pkg::REG_LOCKOUT:   prdata = lockout_ff;
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_three_ff <= tpgd_pkg::ACT_NONE;
         act_four_ff  <= tpgd_pkg::ACT_NONE;
         act_five_ff  <= tpgd_pkg::ACT_NONE;
         lockout_ff   <= tpgd_pkg::LOCKOUT_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            tpgd_pkg::REG_ACT_THREE: act_three_ff <= tpgd_pkg::action_type'(pwdata[2:0]);
            tpgd_pkg::REG_ACT_FOUR:  act_four_ff  <= tpgd_pkg::action_type'(pwdata[2:0]);
            tpgd_pkg::REG_ACT_FIVE:  act_five_ff  <= tpgd_pkg::action_type'(pwdata[2:0]);
            tpgd_pkg::REG_LOCKOUT:   lockout_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   tpgd_resolve #(
      .TIME_BITS(TIME_BITS)
   ) u_resolve (
      .touch_points   (req_touch_points),
      .time_us        (req_time_us),
      .preheat_on     (req_preheat_on),
      .peak           (peak_ff),
      .last_fire      (last_fire_ff),
      .act_three      (act_three_ff),
      .act_four       (act_four_ff),
      .act_five       (act_five_ff),
      .lockout_us     (lockout_ff),
      .mirrors_folded (mirrors_ff),
      .port_open      (port_ff),
      .res            (res)
   );

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && res.emit;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;

   assign beat_new.command       = res.command;
   assign beat_new.command_value = res.command_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= 4'd0;
         last_fire_ff <= '0;
         mirrors_ff   <= 1'b0;
         port_ff      <= 1'b0;
      end else if (accept) begin
         peak_ff    <= res.peak_next;
         mirrors_ff <= res.mirrors_next;
         port_ff    <= res.port_next;
         if (res.fire) begin
            last_fire_ff <= req_time_us;
         end
      end
   end

   // two-entry result queue, head in q0
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && push) begin
         if (count_ff == 2'd1) begin
            q0_ff <= beat_new;
         end else begin
            q0_ff <= q1_ff;
            q1_ff <= beat_new;
         end
      end else if (pop) begin
         q0_ff <= q1_ff;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            q0_ff <= beat_new;
         end else begin
            q1_ff <= beat_new;
         end
      end
   end

   assign rsp_command       = q0_ff.command;
   assign rsp_command_value = q0_ff.command_value;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_peak_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && (req_touch_points == 4'd0) |=> peak_ff == 4'd0)
      else $error("peak not cleared on release");

   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && res.fire) |=> $stable(last_fire_ff))
      else $error("firing time changed without a firing");

   a_emit_needs_fire: assert property (@(posedge clock) disable iff (reset)
      res.emit |-> res.fire && (req_touch_points == 4'd0))
      else $error("command emitted without a firing");

   a_toggle_needs_emit: assert property (@(posedge clock) disable iff (reset)
      !(accept && res.emit) |=> $stable(mirrors_ff) && $stable(port_ff))
      else $error("toggle changed without a command");

endmodule
